// File: hw/rtl/pdgc_pkg.sv
package pdgc_pkg;

  // Input transaction modes
  localparam logic [2:0] MODE_LEFT_START  = 3'd0;
  localparam logic [2:0] MODE_RIGHT_START = 3'd1;
  localparam logic [2:0] MODE_EDGE        = 3'd2;
  localparam logic [2:0] MODE_ORDER       = 3'd3;
  localparam logic [2:0] MODE_RUN         = 3'd4;
  localparam logic [2:0] MODE_READ        = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIDE        = 2'd0;
  localparam logic [1:0] CFG_LEFT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_RIGHT_COUNT = 2'd2;
  localparam logic [1:0] CFG_COLOR_LIMIT = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WT,
    ST_ORD_RD,
    ST_ORD_WT,
    ST_SRC0,
    ST_SRC1,
    ST_A_RD,
    ST_A_WT,
    ST_DST0,
    ST_DST1,
    ST_B_RD,
    ST_B_WT,
    ST_COL_WT,
    ST_SRCH_RD,
    ST_SRCH_WT,
    ST_ASSIGN,
    ST_DONE
  } state_e;

endpackage

// File: hw/rtl/pdgc_ram.sv
module pdgc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/partial_distance_two_greedy_coloring_core.sv
// Loads and out-of-range items: one transaction per cycle while the output is not stalled;
// the result is registered in the cycle after accept. A color read stalls the input in the
// read-wait state before its result is registered. A run first clears the color table,
// then for each order entry reads the vertex and, if colored, its row bounds and edges, for
// each kept middle vertex its row and two-hop colors, probes marks, assigns; then done.
// Reset clears control state and sweeps the color table; no accepts until the sweep ends.
module partial_distance_two_greedy_coloring_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192,
  parameter int MAX_COLORS   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [12:0] index_i,
  input  logic [13:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  result_value_o,
  output logic [1:0]  status_o
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EPW = $clog2(MAX_EDGES + 1);
  localparam int CW  = $clog2(MAX_COLORS);
  localparam int CLW = $clog2(MAX_COLORS + 1);

  function automatic logic [EPW-1:0] cap_edge(input logic [EPW-1:0] p);
    logic [EPW-1:0] r;
    r = (p > EPW'(MAX_EDGES)) ? EPW'(MAX_EDGES) : p;
    return r;
  endfunction

  pdgc_pkg::state_e state_q, state_d;

  logic        side_q;
  logic [10:0] left_count_q, right_count_q;
  logic [8:0]  color_limit_q;

  logic           run_q, run_d;
  logic [VW-1:0]  clr_q, clr_d;
  logic [NW-1:0]  i_q, i_d;
  logic [VW-1:0]  v_q, v_d;
  logic [VW-1:0]  w_q, w_d;
  logic [EPW-1:0] a_q, a_d, aend_q, aend_d, b_q, b_d, bend_q, bend_d;
  logic [CLW-1:0] c_q, c_d, hi_q, hi_d;
  logic           hit_q, hit_d;
  logic [MAX_COLORS-1:0] mvalid_q, mvalid_d;

  logic       out_valid_q, out_valid_d;
  logic [8:0] result_q, result_d;
  logic [1:0] status_q, status_d;

  // Memory ports
  logic           lrs_we, rrs_we, edge_we, ord_we, col_we, mark_we;
  logic [NW-1:0]  rs_waddr, rs_raddr;
  logic [EPW-1:0] rs_wdata, lrs_rd, rrs_rd, src_rd, dst_rd;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [VW-1:0]  edge_wdata, edge_rd;
  logic [VW-1:0]  ord_waddr, ord_wdata, ord_raddr, ord_rd;
  logic [VW-1:0]  col_waddr, col_raddr;
  logic [CLW:0]   col_wdata, col_rd;
  logic [CW-1:0]  mark_waddr, mark_raddr;
  logic [VW-1:0]  mark_rd;

  logic [NW-1:0]  n_left, n_right, n_src, n_dst;
  logic [CLW-1:0] limit;
  logic           accept, out_free;
  logic           u_ok, col_valid;
  logic [CLW-1:0] col_val;

  // Saturate counts and color limit; a zero color limit counts as one
  assign n_left  = (left_count_q > 11'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(left_count_q);
  assign n_right = (right_count_q > 11'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(right_count_q);
  assign n_src   = side_q ? n_right : n_left;
  assign n_dst   = side_q ? n_left : n_right;
  assign limit   = (color_limit_q == 9'd0) ? CLW'(1) :
                   ((32'(color_limit_q) > MAX_COLORS) ? CLW'(MAX_COLORS) : CLW'(color_limit_q));

  assign src_rd    = cap_edge(side_q ? rrs_rd : lrs_rd);
  assign dst_rd    = cap_edge(side_q ? lrs_rd : rrs_rd);
  assign col_valid = col_rd[CLW];
  assign col_val   = col_rd[CLW-1:0];
  assign u_ok      = (NW'(edge_rd) < n_src) && (edge_rd != v_q);

  // Accept only in idle, once the output register drains this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == pdgc_pkg::ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q        <= 1'b0;
      left_count_q  <= 11'd1;
      right_count_q <= 11'd1;
      color_limit_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdgc_pkg::CFG_SIDE:        side_q        <= cfg_data_i[0];
        pdgc_pkg::CFG_LEFT_COUNT:  left_count_q  <= cfg_data_i;
        pdgc_pkg::CFG_RIGHT_COUNT: right_count_q <= cfg_data_i;
        pdgc_pkg::CFG_COLOR_LIMIT: color_limit_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdgc_pkg::ST_CLEAR: begin
        if (clr_q == VW'(MAX_VERTICES - 1)) begin
          state_d = run_q ? pdgc_pkg::ST_ORD_RD : pdgc_pkg::ST_IDLE;
        end
      end
      pdgc_pkg::ST_IDLE: begin
        if (accept && mode_i == pdgc_pkg::MODE_RUN) begin
          state_d = pdgc_pkg::ST_CLEAR;
        end else if (accept && mode_i == pdgc_pkg::MODE_READ &&
                     32'(index_i) < MAX_VERTICES) begin
          state_d = pdgc_pkg::ST_RD_WT;
        end
      end
      pdgc_pkg::ST_RD_WT:  state_d = pdgc_pkg::ST_IDLE;
      pdgc_pkg::ST_ORD_RD: state_d = (i_q >= n_src) ? pdgc_pkg::ST_DONE : pdgc_pkg::ST_ORD_WT;
      pdgc_pkg::ST_ORD_WT: begin
        state_d = (NW'(ord_rd) < n_src) ? pdgc_pkg::ST_SRC0 : pdgc_pkg::ST_ORD_RD;
      end
      pdgc_pkg::ST_SRC0:   state_d = pdgc_pkg::ST_SRC1;
      pdgc_pkg::ST_SRC1:   state_d = pdgc_pkg::ST_A_RD;
      pdgc_pkg::ST_A_RD:   state_d = (a_q < aend_q) ? pdgc_pkg::ST_A_WT : pdgc_pkg::ST_SRCH_RD;
      pdgc_pkg::ST_A_WT: begin
        state_d = (NW'(edge_rd) < n_dst) ? pdgc_pkg::ST_DST0 : pdgc_pkg::ST_A_RD;
      end
      pdgc_pkg::ST_DST0:   state_d = pdgc_pkg::ST_DST1;
      pdgc_pkg::ST_DST1:   state_d = pdgc_pkg::ST_B_RD;
      pdgc_pkg::ST_B_RD:   state_d = (b_q < bend_q) ? pdgc_pkg::ST_B_WT : pdgc_pkg::ST_A_RD;
      pdgc_pkg::ST_B_WT:   state_d = u_ok ? pdgc_pkg::ST_COL_WT : pdgc_pkg::ST_B_RD;
      pdgc_pkg::ST_COL_WT: state_d = pdgc_pkg::ST_B_RD;
      pdgc_pkg::ST_SRCH_RD: begin
        state_d = (c_q == limit) ? pdgc_pkg::ST_ASSIGN : pdgc_pkg::ST_SRCH_WT;
      end
      pdgc_pkg::ST_SRCH_WT: begin
        if (!mvalid_q[c_q[CW-1:0]] || mark_rd != v_q) begin
          state_d = pdgc_pkg::ST_ASSIGN;
        end else begin
          state_d = pdgc_pkg::ST_SRCH_RD;
        end
      end
      pdgc_pkg::ST_ASSIGN: state_d = pdgc_pkg::ST_ORD_RD;
      pdgc_pkg::ST_DONE:   state_d = pdgc_pkg::ST_IDLE;
      default:             state_d = pdgc_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory controls and output register
  always_comb begin
    run_d    = run_q;
    clr_d    = clr_q;
    i_d      = i_q;
    v_d      = v_q;
    w_d      = w_q;
    a_d      = a_q;
    aend_d   = aend_q;
    b_d      = b_q;
    bend_d   = bend_q;
    c_d      = c_q;
    hi_d     = hi_q;
    hit_d    = hit_q;
    mvalid_d = mvalid_q;

    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    status_d    = status_q;

    lrs_we     = 1'b0;
    rrs_we     = 1'b0;
    rs_waddr   = index_i[NW-1:0];
    rs_wdata   = value_i[EPW-1:0];
    rs_raddr   = NW'(v_q);
    edge_we    = 1'b0;
    edge_waddr = index_i[EAW-1:0];
    edge_wdata = value_i[VW-1:0];
    edge_raddr = a_q[EAW-1:0];
    ord_we     = 1'b0;
    ord_waddr  = index_i[VW-1:0];
    ord_wdata  = value_i[VW-1:0];
    ord_raddr  = i_q[VW-1:0];
    col_we     = 1'b0;
    col_waddr  = clr_q;
    col_wdata  = '0;
    col_raddr  = index_i[VW-1:0];
    mark_we    = 1'b0;
    mark_waddr = col_val[CW-1:0];
    mark_raddr = c_q[CW-1:0];

    unique case (state_q)
      pdgc_pkg::ST_CLEAR: begin
        col_we = 1'b1;
        clr_d  = clr_q + VW'(1);
      end
      pdgc_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          result_d    = '0;
          status_d    = pdgc_pkg::STATUS_OK;
          unique case (mode_i) inside
            pdgc_pkg::MODE_LEFT_START, pdgc_pkg::MODE_RIGHT_START: begin
              if (32'(index_i) > MAX_VERTICES || 32'(value_i) > MAX_EDGES) begin
                status_d = pdgc_pkg::STATUS_RANGE;
              end else begin
                lrs_we = (mode_i == pdgc_pkg::MODE_LEFT_START);
                rrs_we = (mode_i == pdgc_pkg::MODE_RIGHT_START);
              end
            end
            pdgc_pkg::MODE_EDGE: begin
              if (32'(index_i) >= MAX_EDGES || 32'(value_i) >= MAX_VERTICES) begin
                status_d = pdgc_pkg::STATUS_RANGE;
              end else begin
                edge_we = 1'b1;
              end
            end
            pdgc_pkg::MODE_ORDER: begin
              if (32'(index_i) >= MAX_VERTICES || 32'(value_i) >= MAX_VERTICES) begin
                status_d = pdgc_pkg::STATUS_RANGE;
              end else begin
                ord_we = 1'b1;
              end
            end
            pdgc_pkg::MODE_RUN: begin
              out_valid_d = 1'b0;
              run_d       = 1'b1;
              clr_d       = '0;
              i_d         = '0;
              hi_d        = '0;
              hit_d       = 1'b0;
              mvalid_d    = '0;
            end
            pdgc_pkg::MODE_READ: begin
              if (32'(index_i) >= MAX_VERTICES) begin
                status_d = pdgc_pkg::STATUS_RANGE;
              end else begin
                out_valid_d = 1'b0;
              end
            end
            default: status_d = pdgc_pkg::STATUS_RANGE;
          endcase
        end
      end
      pdgc_pkg::ST_RD_WT: begin
        out_valid_d = 1'b1;
        if (col_valid) begin
          result_d = 9'(col_val);
          status_d = pdgc_pkg::STATUS_OK;
        end else begin
          result_d = '0;
          status_d = pdgc_pkg::STATUS_RANGE;
        end
      end
      pdgc_pkg::ST_ORD_RD: ;
      pdgc_pkg::ST_ORD_WT: begin
        v_d      = ord_rd;
        rs_raddr = NW'(ord_rd);
        if (NW'(ord_rd) >= n_src) begin
          i_d = i_q + NW'(1);
        end
      end
      pdgc_pkg::ST_SRC0: begin
        a_d      = src_rd;
        rs_raddr = NW'(v_q) + NW'(1);
      end
      pdgc_pkg::ST_SRC1: aend_d = src_rd;
      pdgc_pkg::ST_A_RD: begin
        edge_raddr = a_q[EAW-1:0];
        if (a_q < aend_q) begin
          a_d = a_q + EPW'(1);
        end else begin
          c_d = '0;
        end
      end
      pdgc_pkg::ST_A_WT: begin
        w_d      = edge_rd;
        rs_raddr = NW'(edge_rd);
      end
      pdgc_pkg::ST_DST0: begin
        b_d      = dst_rd;
        rs_raddr = NW'(w_q) + NW'(1);
      end
      pdgc_pkg::ST_DST1: bend_d = dst_rd;
      pdgc_pkg::ST_B_RD: begin
        edge_raddr = b_q[EAW-1:0];
        if (b_q < bend_q) begin
          b_d = b_q + EPW'(1);
        end
      end
      pdgc_pkg::ST_B_WT: col_raddr = edge_rd;
      pdgc_pkg::ST_COL_WT: begin
        // Stamp the neighbour color with the current vertex
        if (col_valid && col_val < limit) begin
          mark_we                      = 1'b1;
          mvalid_d[col_val[CW-1:0]]    = 1'b1;
        end
      end
      pdgc_pkg::ST_SRCH_RD: ;
      pdgc_pkg::ST_SRCH_WT: begin
        if (mvalid_q[c_q[CW-1:0]] && mark_rd == v_q) begin
          c_d = c_q + CLW'(1);
        end
      end
      pdgc_pkg::ST_ASSIGN: begin
        col_we    = 1'b1;
        col_waddr = v_q;
        col_wdata = {1'b1, c_q};
        if (c_q == limit) hit_d = 1'b1;
        if (c_q > hi_q) hi_d = c_q;
        i_d = i_q + NW'(1);
      end
      pdgc_pkg::ST_DONE: begin
        run_d       = 1'b0;
        out_valid_d = 1'b1;
        result_d    = (32'(hi_q) >= MAX_COLORS) ? 9'(MAX_COLORS) : 9'(hi_q + CLW'(1));
        status_d    = hit_q ? pdgc_pkg::STATUS_LIMIT : pdgc_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdgc_pkg::ST_CLEAR;
      run_q       <= 1'b0;
      clr_q       <= '0;
      i_q         <= '0;
      hi_q        <= '0;
      hit_q       <= 1'b0;
      mvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      hi_q        <= hi_d;
      hit_q       <= hit_d;
      mvalid_q    <= mvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    w_q      <= w_d;
    a_q      <= a_d;
    aend_q   <= aend_d;
    b_q      <= b_d;
    bend_q   <= bend_d;
    c_q      <= c_d;
    result_q <= result_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  pdgc_ram #(.Width(EPW), .Depth(MAX_VERTICES + 1)) u_left_start (
    .clk_i, .we_i(lrs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(lrs_rd)
  );

  pdgc_ram #(.Width(EPW), .Depth(MAX_VERTICES + 1)) u_right_start (
    .clk_i, .we_i(rrs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rrs_rd)
  );

  pdgc_ram #(.Width(VW), .Depth(MAX_EDGES)) u_edges (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rd)
  );

  pdgc_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rd)
  );

  pdgc_ram #(.Width(CLW + 1), .Depth(MAX_VERTICES)) u_colors (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(col_raddr), .rdata_o(col_rd)
  );

  pdgc_ram #(.Width(VW), .Depth(MAX_COLORS)) u_marks (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(v_q),
    .raddr_i(mark_raddr), .rdata_o(mark_rd)
  );

endmodule

// File: dv/partial_distance_two_greedy_coloring_core_test.sv
module partial_distance_two_greedy_coloring_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 1024;
  localparam int NE = 8192;
  localparam int NC = 256;

  typedef struct packed {
    logic [8:0] result_value;
    logic [1:0] status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = pdgc_pkg::CFG_SIDE;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = pdgc_pkg::MODE_LEFT_START;
  logic [12:0] index_i = '0;
  logic [13:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [8:0]  result_value_o;
  logic [1:0]  status_o;

  partial_distance_two_greedy_coloring_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // Shadow copy of the block state
  bit [13:0] row_start [2][0:NV];
  bit        row_start_set [2][0:NV];
  bit [9:0]  edge_dst [0:NE-1];
  bit        edge_set [0:NE-1];
  bit [9:0]  visit_seq [0:NV-1];
  bit        visit_set [0:NV-1];
  bit [8:0]  vertex_hue [0:NV-1];
  bit        vertex_hued [0:NV-1];
  bit [9:0]  hue_owner [0:NC-1];
  bit        hue_owned [0:NC-1];
  bit        side_sel = 1'b0;
  bit [10:0] left_num = 11'd1;
  bit [10:0] right_num = 11'd1;
  bit [8:0]  hue_cap = 9'd256;

  answer_t pending_answers [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      burst_left = 0;

  function automatic int clamp_edge(int p);
    return p > NE ? NE : p;
  endfunction

  // Walk the two-hop neighborhood; in dry mode only check that every entry
  // touched has been written. Returns 0 if an unwritten entry would be read.
  function automatic bit color_graph(input bit dry, output logic [8:0] count,
                                     output bit hit);
    int ns, nd, lim, v, a, ae, w, b, be, u, c, hi, src, dst;
    src = side_sel ? 1 : 0;
    dst = 1 - src;
    ns = side_sel ? right_num : left_num;
    nd = side_sel ? left_num : right_num;
    if (ns > NV) ns = NV;
    if (nd > NV) nd = NV;
    lim = hue_cap;
    if (lim < 1) lim = 1;
    if (lim > NC) lim = NC;
    hi = 0;
    hit = 1'b0;
    count = 9'd1;
    if (!dry) begin
      foreach (vertex_hued[k]) vertex_hued[k] = 1'b0;
      foreach (vertex_hue[k]) vertex_hue[k] = '0;
      foreach (hue_owned[k]) hue_owned[k] = 1'b0;
    end
    for (int i = 0; i < ns; i++) begin
      if (!visit_set[i]) return 1'b0;
      v = visit_seq[i];
      if (v >= ns) continue;
      if (!row_start_set[src][v] || !row_start_set[src][v+1]) return 1'b0;
      a = clamp_edge(row_start[src][v]);
      ae = clamp_edge(row_start[src][v+1]);
      for (; a < ae; a++) begin
        if (!edge_set[a]) return 1'b0;
        w = edge_dst[a];
        if (w >= nd) continue;
        if (!row_start_set[dst][w] || !row_start_set[dst][w+1]) return 1'b0;
        b = clamp_edge(row_start[dst][w]);
        be = clamp_edge(row_start[dst][w+1]);
        for (; b < be; b++) begin
          if (!edge_set[b]) return 1'b0;
          u = edge_dst[b];
          if (dry || u >= ns || u == v || !vertex_hued[u]) continue;
          if (vertex_hue[u] >= lim) continue;
          hue_owner[vertex_hue[u]] = 10'(v);
          hue_owned[vertex_hue[u]] = 1'b1;
        end
      end
      if (!dry) begin
        for (c = 0; c < lim; c++)
          if (!hue_owned[c] || hue_owner[c] != v) break;
        if (c == lim) hit = 1'b1;
        vertex_hue[v] = 9'(c);
        vertex_hued[v] = 1'b1;
        if (c > hi) hi = c;
      end
    end
    count = 9'((hi + 1 > NC) ? NC : hi + 1);
    return 1'b1;
  endfunction

  // Update the shadow state for one accepted transaction and return its answer
  function automatic answer_t predict_answer(logic [2:0] mode, int idx, int val);
    answer_t    ans;
    logic [8:0] cnt;
    bit         hit;
    ans = '{result_value: '0, status: pdgc_pkg::STATUS_OK};
    case (mode) inside
      pdgc_pkg::MODE_LEFT_START, pdgc_pkg::MODE_RIGHT_START: begin
        if (idx > NV || val > NE) ans.status = pdgc_pkg::STATUS_RANGE;
        else begin
          row_start[mode == pdgc_pkg::MODE_RIGHT_START][idx] = 14'(val);
          row_start_set[mode == pdgc_pkg::MODE_RIGHT_START][idx] = 1'b1;
        end
      end
      pdgc_pkg::MODE_EDGE: begin
        if (idx >= NE || val >= NV) ans.status = pdgc_pkg::STATUS_RANGE;
        else begin
          edge_dst[idx] = 10'(val);
          edge_set[idx] = 1'b1;
        end
      end
      pdgc_pkg::MODE_ORDER: begin
        if (idx >= NV || val >= NV) ans.status = pdgc_pkg::STATUS_RANGE;
        else begin
          visit_seq[idx] = 10'(val);
          visit_set[idx] = 1'b1;
        end
      end
      pdgc_pkg::MODE_RUN: begin
        void'(color_graph(1'b0, cnt, hit));
        ans.result_value = cnt;
        ans.status = hit ? pdgc_pkg::STATUS_LIMIT : pdgc_pkg::STATUS_OK;
      end
      pdgc_pkg::MODE_READ: begin
        if (idx >= NV || !vertex_hued[idx]) ans.status = pdgc_pkg::STATUS_RANGE;
        else ans.result_value = vertex_hue[idx];
      end
      default: ans.status = pdgc_pkg::STATUS_RANGE;
    endcase
    return ans;
  endfunction

  // Drive one transaction in bursts with random gaps, record its answer
  task automatic send_item(logic [2:0] mode, int idx, int val);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    index_i <= 13'(idx);
    value_i <= 14'(val);
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
    pending_answers.push_back(predict_answer(mode, idx, val));
  endtask

  // Hold off the sender until every answer is back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all registers while the block is idle
  task automatic configure(bit side, int lnum, int rnum, int cap);
    logic [1:0] idx [4];
    int         data [4];
    drain();
    idx = '{pdgc_pkg::CFG_SIDE, pdgc_pkg::CFG_LEFT_COUNT, pdgc_pkg::CFG_RIGHT_COUNT,
            pdgc_pkg::CFG_COLOR_LIMIT};
    data = '{side, lnum, rnum, cap};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= 11'(data[i]);
      @(posedge clk_i);
      case (idx[i])
        pdgc_pkg::CFG_SIDE:        side_sel = data[i][0];
        pdgc_pkg::CFG_LEFT_COUNT:  left_num = data[i][10:0];
        pdgc_pkg::CFG_RIGHT_COUNT: right_num = data[i][10:0];
        default:                   hue_cap = data[i][8:0];
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Issue a run only if it touches written entries; otherwise read a color
  task automatic try_run();
    logic [8:0] cnt;
    bit         hit;
    if (color_graph(1'b1, cnt, hit))
      send_item(pdgc_pkg::MODE_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383));
    else
      send_item(pdgc_pkg::MODE_READ, $urandom_range(0, 31), 0);
  endtask

  task automatic test_load_ranges();
    send_item(pdgc_pkg::MODE_READ, 0, 0);
    send_item(pdgc_pkg::MODE_READ, 8191, 16383);
    send_item(3'd6, $urandom_range(0, 8191), $urandom_range(0, 16383));
    send_item(3'd7, $urandom_range(0, 8191), $urandom_range(0, 16383));
    send_item(pdgc_pkg::MODE_LEFT_START, NV + 1, 0);
    send_item(pdgc_pkg::MODE_LEFT_START, 0, NE + 1);
    send_item(pdgc_pkg::MODE_RIGHT_START, 8191, 16383);
    send_item(pdgc_pkg::MODE_LEFT_START, NV, NE);
    send_item(pdgc_pkg::MODE_EDGE, 0, NV);
    send_item(pdgc_pkg::MODE_EDGE, 8191, NV - 1);
    send_item(pdgc_pkg::MODE_ORDER, NV, 0);
    send_item(pdgc_pkg::MODE_ORDER, 0, 16383);
    send_item(pdgc_pkg::MODE_ORDER, NV - 1, NV - 1);
  endtask

  // One left vertex whose row ends at the top of the edge list, then a bad row
  task automatic test_tiny_graph();
    send_item(pdgc_pkg::MODE_ORDER, 0, 0);
    send_item(pdgc_pkg::MODE_LEFT_START, 0, NE - 2);
    send_item(pdgc_pkg::MODE_LEFT_START, 1, NE);
    send_item(pdgc_pkg::MODE_EDGE, NE - 2, 0);
    send_item(pdgc_pkg::MODE_EDGE, NE - 1, 5);
    send_item(pdgc_pkg::MODE_RIGHT_START, 0, 0);
    send_item(pdgc_pkg::MODE_RIGHT_START, 1, 1);
    send_item(pdgc_pkg::MODE_EDGE, 0, 0);
    try_run();
    send_item(pdgc_pkg::MODE_READ, 0, 0);
    send_item(pdgc_pkg::MODE_LEFT_START, 1, 3);
    try_run();
    send_item(pdgc_pkg::MODE_READ, 0, 0);
  endtask

  task automatic test_zero_count();
    configure(1'b0, 0, 1, 0);
    try_run();
    send_item(pdgc_pkg::MODE_READ, 0, 0);
  endtask

  // Colored side small, other side at the saturated maximum count
  task automatic test_wide_count(bit side);
    logic [2:0] src_mode, dst_mode;
    int         src_rows [4] = '{0, 2, 4, 6};
    int         src_edges [6] = '{0, 1023, 1023, 512, 1000, 1000};
    int         dst_ids [8] = '{0, 1, 512, 513, 1000, 1001, 1023, 1024};
    int         dst_rows [8] = '{10, 12, 11, 13, 10, 10, 10, 13};
    int         two_hop [3] = '{0, 7, 2};
    int         seq [3] = '{2, 0, 1};
    src_mode = side ? pdgc_pkg::MODE_RIGHT_START : pdgc_pkg::MODE_LEFT_START;
    dst_mode = side ? pdgc_pkg::MODE_LEFT_START : pdgc_pkg::MODE_RIGHT_START;
    configure(side, side ? 2047 : 3, side ? 3 : 1024, side ? 511 : 2);
    foreach (src_rows[i]) send_item(src_mode, i, src_rows[i]);
    foreach (src_edges[i]) send_item(pdgc_pkg::MODE_EDGE, i, src_edges[i]);
    foreach (dst_ids[i]) send_item(dst_mode, dst_ids[i], dst_rows[i]);
    foreach (two_hop[i]) send_item(pdgc_pkg::MODE_EDGE, 10 + i, two_hop[i]);
    foreach (seq[i]) send_item(pdgc_pkg::MODE_ORDER, i, seq[i]);
    try_run();
    for (int i = 0; i < 3; i++) send_item(pdgc_pkg::MODE_READ, i, 0);
  endtask

  // Random small graphs, each colored under one limit and sometimes recolored, then noise
  task automatic test_random_graphs();
    int  nl, nr, ns, maxdeg, base, pos, span_end, cap, caps [7];
    bit  side;
    int  lstart [0:32];
    int  rstart [0:32];
    caps = '{0, 1, 2, 3, 256, 511, 4};
    while (items_sent < 1400) begin
      side = 1'($urandom_range(0, 1));
      nl = $urandom_range(1, 14);
      nr = $urandom_range(1, 14);
      ns = side ? nr : nl;
      maxdeg = $urandom_range(0, 4);
      base = $urandom_range(0, 7800);
      cap = ($urandom_range(0, 1) == 0) ? caps[$urandom_range(0, 6)]
                                        : $urandom_range(1, 20);
      configure(side, nl, nr, cap);
      pos = base;
      for (int i = 0; i <= nl; i++) begin
        lstart[i] = pos;
        if (i < nl) pos += $urandom_range(0, maxdeg);
      end
      for (int i = 0; i <= nr; i++) begin
        rstart[i] = pos;
        if (i < nr) pos += $urandom_range(0, maxdeg);
      end
      span_end = pos + 4;
      for (int i = 0; i <= nl; i++) send_item(pdgc_pkg::MODE_LEFT_START, i, lstart[i]);
      for (int i = 0; i <= nr; i++) send_item(pdgc_pkg::MODE_RIGHT_START, i, rstart[i]);
      // Stretch a row now and then, which can also leave a bad row after it
      if ($urandom_range(0, 3) == 0)
        send_item(pdgc_pkg::MODE_LEFT_START, $urandom_range(0, nl), lstart[0] +
                  $urandom_range(0, 6));
      for (int a = base; a < span_end; a++) begin
        if (a < rstart[0])
          send_item(pdgc_pkg::MODE_EDGE, a, $urandom_range(0, ($urandom_range(0, 7) == 0)
                                                 ? nr + 2 : nr - 1));
        else
          send_item(pdgc_pkg::MODE_EDGE, a, $urandom_range(0, ($urandom_range(0, 7) == 0)
                                                 ? nl + 2 : nl - 1));
      end
      for (int i = 0; i < ns; i++)
        send_item(pdgc_pkg::MODE_ORDER, i, $urandom_range(0, ($urandom_range(0, 5) == 0)
                                                ? ns + 2 : ns - 1));
      try_run();
      for (int i = 0; i < ns + 2; i++) send_item(pdgc_pkg::MODE_READ, i, 0);
      // Sometimes recolor the same graph under a random limit from 1 to 3
      if ($urandom_range(0, 1) == 0) begin
        configure(side, nl, nr, $urandom_range(1, 3));
        try_run();
        for (int i = 0; i < ns; i++)
          send_item(pdgc_pkg::MODE_READ, i, $urandom_range(0, 16383));
      end
      repeat ($urandom_range(2, 10)) begin
        logic [2:0] m;
        m = 3'($urandom_range(0, 7));
        if (m == pdgc_pkg::MODE_RUN) try_run();
        else send_item(m, $urandom_range(0, 8191), $urandom_range(0, 16383));
      end
    end
  endtask

  // Receiver stall pattern: quiet stretches, light stalling, heavy stalling
  int stall_kind = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_kind)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // Compare each result transaction with the oldest expected answer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value %0d status %0d", result_value_o, status_o);
      end else begin
        want = pending_answers.pop_front();
        if (result_value_o !== want.result_value || status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.result_value, want.status, result_value_o, status_o);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_ranges();
    test_tiny_graph();
    test_zero_count();
    test_wide_count(1'b0);
    test_wide_count(1'b1);
    test_random_graphs();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
